// ===== rtl/tcn_pkg.sv =====
// tcn_pkg: shared constants and types for the triangle centroid/normal block.
// Depends on nothing; compile first.
package tcn_pkg;

  localparam int COORD_WIDTH      = 16;
  localparam int NORMAL_FRAC_BITS = 14;
  localparam int OUT_WIDTH        = 16;
  localparam int AXES             = 3;
  localparam int PRE_STAGES       = 7;

  typedef struct packed {
    logic neg;
    logic zero;
  } tcn_flags_t;

  typedef struct packed {
    logic [OUT_WIDTH-1:0] mid_x;
    logic [OUT_WIDTH-1:0] mid_y;
    logic [OUT_WIDTH-1:0] mid_z;
    logic                 degenerate;
    logic                 final_out;
  } tcn_side_t;

endpackage

// ===== rtl/tcn_face_if.sv =====
// tcn_face_if: valid/ready channel carrying one triangle of three vertices.
// Depends on tcn_pkg.
interface tcn_face_if #(
  parameter int COORD_WIDTH = tcn_pkg::COORD_WIDTH
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] a_x;
  logic signed [COORD_WIDTH-1:0] a_y;
  logic signed [COORD_WIDTH-1:0] a_z;
  logic signed [COORD_WIDTH-1:0] b_x;
  logic signed [COORD_WIDTH-1:0] b_y;
  logic signed [COORD_WIDTH-1:0] b_z;
  logic signed [COORD_WIDTH-1:0] c_x;
  logic signed [COORD_WIDTH-1:0] c_y;
  logic signed [COORD_WIDTH-1:0] c_z;
  logic                          final_face;

  modport source (
    output valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, final_face,
    input  ready
  );
  modport sink (
    input  valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, final_face,
    output ready
  );
endinterface

// ===== rtl/tcn_result_if.sv =====
// tcn_result_if: valid/ready channel carrying centroid, unit normal and flags.
// Depends on tcn_pkg.
interface tcn_result_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [tcn_pkg::OUT_WIDTH-1:0]  mid_x;
  logic signed [tcn_pkg::OUT_WIDTH-1:0]  mid_y;
  logic signed [tcn_pkg::OUT_WIDTH-1:0]  mid_z;
  logic signed [tcn_pkg::OUT_WIDTH-1:0]  unit_x;
  logic signed [tcn_pkg::OUT_WIDTH-1:0]  unit_y;
  logic signed [tcn_pkg::OUT_WIDTH-1:0]  unit_z;
  logic                                  degenerate;
  logic                                  final_out;

  modport source (
    output valid, mid_x, mid_y, mid_z, unit_x, unit_y, unit_z, degenerate, final_out,
    input  ready
  );
  modport sink (
    input  valid, mid_x, mid_y, mid_z, unit_x, unit_y, unit_z, degenerate, final_out,
    output ready
  );
endinterface

// ===== rtl/tcn_unit_lane.sv =====
// tcn_unit_lane: pipelined divide of a squared component by the squared length,
// then a digit-by-digit square root and rounding to one signed unit component.
// Depends on tcn_pkg.
module tcn_unit_lane #(
  parameter int  COORD_WIDTH      = tcn_pkg::COORD_WIDTH,
  parameter int  NORMAL_FRAC_BITS = tcn_pkg::NORMAL_FRAC_BITS,
  localparam int MW  = 2*COORD_WIDTH + 2,
  localparam int M2W = 2*MW,
  localparam int SW  = M2W + 2
) (
  input  logic                                 clk,
  input  logic                                 en,
  input  logic [M2W-1:0]                       sq,
  input  logic [SW-1:0]                        len2,
  input  tcn_pkg::tcn_flags_t                  flags,
  output logic signed [tcn_pkg::OUT_WIDTH-1:0] unit
);

  localparam int QW   = 2*NORMAL_FRAC_BITS + 3;
  localparam int SQ   = NORMAL_FRAC_BITS + 2;
  localparam int RW   = 2*SQ;
  localparam int REMW = SQ + 2;
  localparam int OW   = tcn_pkg::OUT_WIDTH;
  localparam int EW   = ((SQ > OW) ? SQ : OW) + 1;

  logic [SW-1:0]       d_rem [QW];
  logic [SW-1:0]       d_den [QW];
  logic [QW-1:0]       d_q   [QW];
  tcn_pkg::tcn_flags_t d_f   [QW];

  logic [REMW-1:0]     r_rem  [SQ];
  logic [SQ-1:0]       r_root [SQ];
  logic [RW-1:0]       r_x    [SQ];
  tcn_pkg::tcn_flags_t r_f    [SQ];

  // restoring divide, one quotient bit per stage
  for (genvar d = 0; d < QW; d++) begin : g_div
    logic [SW:0]         num;
    logic [SW-1:0]       den;
    logic [QW-1:0]       q_in;
    tcn_pkg::tcn_flags_t f_in;
    logic [SW:0]         diff;
    logic                ge;

    if (d == 0) begin : g_first
      assign num  = (SW+1)'(sq);
      assign den  = len2;
      assign q_in = '0;
      assign f_in = flags;
    end else begin : g_next
      assign num  = {d_rem[d-1], 1'b0};
      assign den  = d_den[d-1];
      assign q_in = d_q[d-1];
      assign f_in = d_f[d-1];
    end

    assign diff = num - {1'b0, den};
    assign ge   = (num >= {1'b0, den});

    always_ff @(posedge clk) begin
      if (en) begin
        d_rem[d] <= ge ? diff[SW-1:0] : num[SW-1:0];
        d_den[d] <= den;
        d_q[d]   <= {q_in[QW-2:0], ge};
        d_f[d]   <= f_in;
      end
    end
  end

  // integer square root, one root bit per stage
  for (genvar j = 0; j < SQ; j++) begin : g_sqrt
    logic [REMW-1:0]     rem_in;
    logic [SQ-1:0]       root_in;
    logic [RW-1:0]       x_in;
    tcn_pkg::tcn_flags_t f_in;
    logic [REMW+1:0]     t;
    logic [REMW+1:0]     trial;
    logic [REMW+1:0]     diff;
    logic                ge;

    if (j == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign x_in    = RW'(d_q[QW-1]);
      assign f_in    = d_f[QW-1];
    end else begin : g_next
      assign rem_in  = r_rem[j-1];
      assign root_in = r_root[j-1];
      assign x_in    = r_x[j-1];
      assign f_in    = r_f[j-1];
    end

    assign t     = {rem_in, x_in[RW-1:RW-2]};
    assign trial = (REMW+2)'({root_in, 2'b01});
    assign diff  = t - trial;
    assign ge    = (t >= trial);

    always_ff @(posedge clk) begin
      if (en) begin
        r_rem[j]  <= ge ? diff[REMW-1:0] : t[REMW-1:0];
        r_root[j] <= {root_in[SQ-2:0], ge};
        r_x[j]    <= {x_in[RW-3:0], 2'b00};
        r_f[j]    <= f_in;
      end
    end
  end

  logic [SQ:0]   root_p1;
  logic [EW-1:0] mag_ext;
  logic [EW-1:0] val;

  assign root_p1 = (SQ+1)'(r_root[SQ-1]) + (SQ+1)'(1);
  assign mag_ext = EW'(root_p1[SQ:1]);
  assign val     = r_f[SQ-1].neg ? (~mag_ext + EW'(1)) : mag_ext;

  always_ff @(posedge clk) begin
    if (en) begin
      unit <= r_f[SQ-1].zero ? '0 : val[OW-1:0];
    end
  end

endmodule

// ===== rtl/triangle_centroid_normal.sv =====
// triangle_centroid_normal: centroid and unit face normal of one triangle.
// Depends on tcn_pkg, tcn_face_if, tcn_result_if and tcn_unit_lane.
//
// Usage:
//   face   (sink)   : one triangle per transfer, vertices a, b, c in signed Q8.8
//                     plus the final_face marker.
//   result (source) : centroid (Q8.8, truncated toward zero), unit normal of
//                     (a-c) x (b-c) in signed Q1.14 rounded to nearest, the
//                     degenerate flag (zero normal, unit outputs zero) and
//                     final_out, a copy of final_face.
//   Throughput: one triangle per cycle, sustained while the result side is not stalled.
//   Pipeline: from input transfer to result valid, the stages of differences,
//     cross products and squared length, then one-bit-per-stage division, then
//     square root and one rounding stage.
//   Stall: when a result is held by a low result.ready, the whole pipeline
//     holds; face.ready drops only while the last stage is full and stalled.
//     Nothing is dropped or repeated.
//   Reset (rst, synchronous): clears all valid bits; no results are pending.
module triangle_centroid_normal #(
  parameter int COORD_WIDTH      = tcn_pkg::COORD_WIDTH,
  parameter int NORMAL_FRAC_BITS = tcn_pkg::NORMAL_FRAC_BITS
) (
  input logic          clk,
  input logic          rst,
  tcn_face_if.sink     face,
  tcn_result_if.source result
);

  localparam int CW   = COORD_WIDTH;
  localparam int AX   = tcn_pkg::AXES;
  localparam int OW   = tcn_pkg::OUT_WIDTH;
  localparam int PW   = 2*CW + 2;
  localparam int NW   = 2*CW + 3;
  localparam int MW   = 2*CW + 2;
  localparam int H    = CW + 1;
  localparam int M2W  = 2*MW;
  localparam int SW   = M2W + 2;
  localparam int LAT  = (2*NORMAL_FRAC_BITS + 3) + (NORMAL_FRAC_BITS + 2) + 1;
  localparam int NST  = tcn_pkg::PRE_STAGES + LAT;
  localparam int CEW  = ((CW > OW) ? CW : OW) + 1;
  localparam int D3_SHIFT = CW + 3;
  localparam logic [63:0] D3_MUL64 = ((64'd1 << D3_SHIFT) + 64'd2) / 64'd3;
  localparam logic [CW+1:0] D3_MUL = D3_MUL64[CW+1:0];

  logic [NST-1:0] vld;
  logic           en;

  assign en           = !vld[NST-1] || result.ready;
  assign face.ready   = en;
  assign result.valid = vld[NST-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NST-2:0], face.valid};
    end
  end

  logic signed [CW-1:0] av [AX];
  logic signed [CW-1:0] bv [AX];
  logic signed [CW-1:0] cv [AX];

  assign av[0] = face.a_x;
  assign av[1] = face.a_y;
  assign av[2] = face.a_z;
  assign bv[0] = face.b_x;
  assign bv[1] = face.b_y;
  assign bv[2] = face.b_z;
  assign cv[0] = face.c_x;
  assign cv[1] = face.c_y;
  assign cv[2] = face.c_z;

  // stage 1: edge vectors and coordinate sums
  logic signed [CW:0]   s1_u   [AX];
  logic signed [CW:0]   s1_v   [AX];
  logic signed [CW+1:0] s1_sum [AX];
  logic                 s1_fin;

  // stage 2: cross product terms, centroid magnitude
  logic signed [PW-1:0] s2_p    [AX];
  logic signed [PW-1:0] s2_q    [AX];
  logic [CW:0]          s2_cmag [AX];
  logic [AX-1:0]        s2_cneg;
  logic                 s2_fin;

  // stage 3: cross product, centroid reciprocal product
  logic signed [NW-1:0] s3_n     [AX];
  logic [2*CW+2:0]      s3_cprod [AX];
  logic [AX-1:0]        s3_cneg;
  logic                 s3_fin;

  // stage 4: magnitudes, signs, centroid
  logic [MW-1:0]        s4_mag [AX];
  logic [AX-1:0]        s4_neg;
  logic                 s4_zero;
  logic [OW-1:0]        s4_mid [AX];
  logic                 s4_fin;

  // stage 5: partial products of squares
  logic [2*H-1:0]       s5_ll [AX];
  logic [2*H-1:0]       s5_hh [AX];
  logic [2*H-1:0]       s5_hl [AX];
  logic [AX-1:0]        s5_neg;
  logic                 s5_zero;
  logic [OW-1:0]        s5_mid [AX];
  logic                 s5_fin;

  // stage 6: squares
  logic [M2W-1:0]       s6_sq [AX];
  logic [AX-1:0]        s6_neg;
  logic                 s6_zero;
  logic [OW-1:0]        s6_mid [AX];
  logic                 s6_fin;

  // stage 7: squared length
  logic [M2W-1:0]       s7_sq [AX];
  logic [SW-1:0]        s7_len2;
  logic [AX-1:0]        s7_neg;
  logic                 s7_zero;
  logic [OW-1:0]        s7_mid [AX];
  logic                 s7_fin;

  logic [NW-1:0]        nabs  [AX];
  logic [CW+1:0]        cabs  [AX];
  logic [CEW-1:0]       cquot [AX];
  logic [CEW-1:0]       csgn  [AX];
  logic [AX-1:0]        nz;

  for (genvar i = 0; i < AX; i++) begin : g_axis
    localparam int I1 = (i + 1) % 3;
    localparam int I2 = (i + 2) % 3;

    assign cabs[i]  = s1_sum[i][CW+1] ? (~s1_sum[i] + (CW+2)'(1)) : s1_sum[i];
    assign nabs[i]  = s3_n[i][NW-1] ? (~s3_n[i] + NW'(1)) : s3_n[i];
    assign nz[i]    = (s3_n[i] != '0);
    assign cquot[i] = CEW'(s3_cprod[i][2*CW+2:D3_SHIFT]);
    assign csgn[i]  = s3_cneg[i] ? (~cquot[i] + CEW'(1)) : cquot[i];

    always_ff @(posedge clk) begin
      if (en) begin
        s1_u[i]    <= {av[i][CW-1], av[i]} - {cv[i][CW-1], cv[i]};
        s1_v[i]    <= {bv[i][CW-1], bv[i]} - {cv[i][CW-1], cv[i]};
        s1_sum[i]  <= {{2{av[i][CW-1]}}, av[i]} + {{2{bv[i][CW-1]}}, bv[i]}
                    + {{2{cv[i][CW-1]}}, cv[i]};

        s2_p[i]    <= s1_u[I1] * s1_v[I2];
        s2_q[i]    <= s1_u[I2] * s1_v[I1];
        s2_cmag[i] <= cabs[i][CW:0];
        s2_cneg[i] <= s1_sum[i][CW+1];

        s3_n[i]     <= {s2_p[i][PW-1], s2_p[i]} - {s2_q[i][PW-1], s2_q[i]};
        s3_cprod[i] <= s2_cmag[i] * D3_MUL;
        s3_cneg[i]  <= s2_cneg[i];

        s4_mag[i] <= nabs[i][MW-1:0];
        s4_neg[i] <= s3_n[i][NW-1];
        s4_mid[i] <= csgn[i][OW-1:0];

        s5_ll[i]  <= s4_mag[i][H-1:0] * s4_mag[i][H-1:0];
        s5_hh[i]  <= s4_mag[i][MW-1:H] * s4_mag[i][MW-1:H];
        s5_hl[i]  <= s4_mag[i][MW-1:H] * s4_mag[i][H-1:0];
        s5_neg[i] <= s4_neg[i];
        s5_mid[i] <= s4_mid[i];

        s6_sq[i]  <= (M2W'(s5_hh[i]) << (2*H)) + (M2W'(s5_hl[i]) << (H+1))
                   + M2W'(s5_ll[i]);
        s6_neg[i] <= s5_neg[i];
        s6_mid[i] <= s5_mid[i];

        s7_sq[i]  <= s6_sq[i];
        s7_neg[i] <= s6_neg[i];
        s7_mid[i] <= s6_mid[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_fin  <= face.final_face;
      s2_fin  <= s1_fin;
      s3_fin  <= s2_fin;
      s4_fin  <= s3_fin;
      s4_zero <= (nz == '0);
      s5_fin  <= s4_fin;
      s5_zero <= s4_zero;
      s6_fin  <= s5_fin;
      s6_zero <= s5_zero;
      s7_fin  <= s6_fin;
      s7_zero <= s6_zero;
      s7_len2 <= SW'(s6_sq[0]) + SW'(s6_sq[1]) + SW'(s6_sq[2]);
    end
  end

  // normal lanes
  logic signed [OW-1:0] unit [AX];

  for (genvar i = 0; i < AX; i++) begin : g_lane
    tcn_pkg::tcn_flags_t lane_flags;

    assign lane_flags.neg  = s7_neg[i];
    assign lane_flags.zero = s7_zero;

    tcn_unit_lane #(
      .COORD_WIDTH      (COORD_WIDTH),
      .NORMAL_FRAC_BITS (NORMAL_FRAC_BITS)
    ) u_lane (
      .clk   (clk),
      .en    (en),
      .sq    (s7_sq[i]),
      .len2  (s7_len2),
      .flags (lane_flags),
      .unit  (unit[i])
    );
  end

  // hold centroid and flags alongside the lanes
  tcn_pkg::tcn_side_t side [LAT];
  tcn_pkg::tcn_side_t side_in;

  assign side_in.mid_x      = s7_mid[0];
  assign side_in.mid_y      = s7_mid[1];
  assign side_in.mid_z      = s7_mid[2];
  assign side_in.degenerate = s7_zero;
  assign side_in.final_out  = s7_fin;

  always_ff @(posedge clk) begin
    if (en) begin
      side[0] <= side_in;
      for (int k = 1; k < LAT; k++) begin
        side[k] <= side[k-1];
      end
    end
  end

  assign result.mid_x      = side[LAT-1].mid_x;
  assign result.mid_y      = side[LAT-1].mid_y;
  assign result.mid_z      = side[LAT-1].mid_z;
  assign result.degenerate = side[LAT-1].degenerate;
  assign result.final_out  = side[LAT-1].final_out;
  assign result.unit_x     = unit[0];
  assign result.unit_y     = unit[1];
  assign result.unit_z     = unit[2];

  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.degenerate |->
      result.unit_x == '0 && result.unit_y == '0 && result.unit_z == '0)
    else $error("degenerate result carries a nonzero normal");

  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    face.valid && face.ready |=> vld[0])
    else $error("transfer on face did not enter the pipeline");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !result.valid)
    else $error("result valid right after reset");

endmodule
